// ----- sv/bucketed_hash_kv_table_assert.svh -----
// assertion macros for the bucketed hash table
`ifndef BUCKETED_HASH_KV_TABLE_ASSERT_SVH
`define BUCKETED_HASH_KV_TABLE_ASSERT_SVH
`ifndef SYNTH
`define BHKV_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
`define BHKV_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define BHKV_ASSERT_IMP(lbl, clk, rstn, a, c)
`define BHKV_ASSERT_NXT(lbl, clk, rstn, a, c)
`endif
`endif

// ----- sv/bhkv_pkg.sv -----
// ----------------------------------------------------------------------------
// bhkv_pkg
// shared constants and types of the bucketed hash table
// ----------------------------------------------------------------------------
`default_nettype none
package bhkv_pkg;
  localparam int unsigned WAYS_DEF        = 16;
  localparam int unsigned MAX_BUCKETS_DEF = 256;
  localparam int unsigned BLOCK_BITS_DEF  = 32;

  localparam logic [2:0] OP_GET = 3'd0;
  localparam logic [2:0] OP_PUT = 3'd1;
  localparam logic [2:0] OP_UPD = 3'd2;
  localparam logic [2:0] OP_DEL = 3'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_MISSING = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_WFAIL   = 3'd3;
  localparam logic [2:0] ST_BADOP   = 3'd4;

  typedef struct packed {
    logic [2:0] status;
    logic       hit;
    logic [11:0] entry_index;
    logic [31:0] found_block;
    logic [31:0] freed_block;
    logic       freed_valid;
  } result_t;
endpackage
`default_nettype wire

// ----- sv/bhkv_mod.sv -----
// ----------------------------------------------------------------------------
// bhkv_mod
// iterative hash modulo bucket count, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module bhkv_mod import bhkv_pkg::*; #(
  parameter int unsigned BW = 9
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [31:0]   hash_i,
  input  wire logic [BW-1:0] div_i,
  output logic               done_o,
  output logic [BW-1:0]      rem_o
);
  logic [31:0]   num_q, num_d;
  logic [BW-1:0] rem_q, rem_d;
  logic [5:0]    cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic [BW:0]   sh;

  always_comb begin
    num_d = num_q; rem_d = rem_q; cnt_d = cnt_q; busy_d = busy_q;
    sh = {rem_q, num_q[31]};
    done_o = 1'b0;
    if (start_i) begin
      num_d = hash_i; rem_d = '0; cnt_d = 6'd32; busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0; done_o = 1'b1;
      end else begin
        num_d = {num_q[30:0], 1'b0};
        rem_d = (sh >= {1'b0, div_i}) ? BW'(sh - {1'b0, div_i}) : sh[BW-1:0];
        cnt_d = cnt_q - 6'd1;
      end
    end
  end
  assign rem_o = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d;
  end
endmodule
`default_nettype wire

// ----- sv/bucketed_hash_kv_table.sv -----
// flow from input transaction to result valid: the modulo state, then one read and one
// compare state per way, then one write-back state; a bad opcode skips to the output
// throughput: one transaction at a time; the next is taken once the result leaves
// reset: a clearing pass sweeps all MAX_BUCKETS*WAYS entries of the store, no
// transaction is accepted meanwhile; bucket_count resets to 256
// ----------------------------------------------------------------------------
// bucketed_hash_kv_table
// set-associative key tag table held in one synchronous memory
// ----------------------------------------------------------------------------
`default_nettype none
`include "bucketed_hash_kv_table_assert.svh"
module bucketed_hash_kv_table import bhkv_pkg::*; #(
  parameter int unsigned WAYS        = WAYS_DEF,
  parameter int unsigned MAX_BUCKETS = MAX_BUCKETS_DEF,
  parameter int unsigned BLOCK_BITS  = BLOCK_BITS_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [8:0]   cfg_wdata_i,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // opcode[2:0], bucket_hash[34:3], key_tag_high[98:35], key_tag_low[162:99],
  // new_block[194:163], write_ok[195], zero fill to 200
  input  wire logic [199:0] s_axis_tdata_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // status[2:0], hit[3], entry_index[15:4], found_block[47:16],
  // freed_block[79:48], freed_valid[80], zero fill to 88
  output logic [87:0]       m_axis_tdata_o
);
  localparam int unsigned DEPTH = MAX_BUCKETS * WAYS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned BKW   = $clog2(MAX_BUCKETS + 1);
  localparam int unsigned EW    = 128 + BLOCK_BITS;

  typedef enum logic [6:0] {
    S_CLR = 7'b0000001, S_IDLE = 7'b0000010, S_MOD = 7'b0000100,
    S_RD = 7'b0001000, S_CMP = 7'b0010000, S_WB = 7'b0100000,
    S_OUT = 7'b1000000
  } state_e;

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rdata_q;

  state_e state_q, state_d;
  logic [8:0] bc_q;
  logic [2:0] op_q; logic [127:0] tag_q;
  logic [BLOCK_BITS-1:0] nb_q; logic okin_q;
  logic [AW-1:0] base_q, addr_q, addr_d, clr_q;
  logic [WW:0] way_q, way_d;
  logic mfound_q, mfound_d, efound_q, efound_d;
  logic [WW-1:0] mway_q, mway_d, eway_q, eway_d;
  logic [BLOCK_BITS-1:0] mblk_q, mblk_d;
  result_t res_q, res_d;
  logic we; logic [AW-1:0] waddr; logic [EW-1:0] wdata;

  logic [BKW-1:0] bc_eff;
  logic mod_done; logic [BKW-1:0] rem;
  always_comb begin
    if (bc_q == 9'd0) bc_eff = BKW'(1);
    else if (32'(bc_q) > MAX_BUCKETS) bc_eff = BKW'(MAX_BUCKETS);
    else bc_eff = BKW'(bc_q);
  end

  bhkv_mod #(.BW(BKW)) u_mod (
    .clk_i, .rst_ni, .start_i(state_q == S_IDLE && s_axis_tvalid_i &&
      s_axis_tdata_i[2:0] <= OP_DEL),
    .hash_i(s_axis_tdata_i[34:3]), .div_i(bc_eff), .done_o(mod_done), .rem_o(rem)
  );

  logic nz, ok, e_match, e_empty;
  logic [AW-1:0] idx;
  logic [BLOCK_BITS-1:0] oblk;
  assign nz = tag_q != '0;
  assign ok = okin_q && nb_q != '0;
  assign e_empty = rdata_q[EW-1:BLOCK_BITS] == '0;
  assign e_match = nz && rdata_q[EW-1:BLOCK_BITS] == tag_q;
  assign idx = base_q + AW'(mfound_q ? mway_q : eway_q);
  assign oblk = mfound_q ? mblk_q : '0;

  always_comb begin
    state_d = state_q; addr_d = addr_q; way_d = way_q;
    mfound_d = mfound_q; mway_d = mway_q; efound_d = efound_q; eway_d = eway_q;
    mblk_d = mblk_q; res_d = res_q;
    we = 1'b0; waddr = idx; wdata = '0;
    unique case (state_q)
      S_CLR: begin
        we = 1'b1; waddr = clr_q;
        if (clr_q == AW'(DEPTH - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          res_d = '0;
          if (s_axis_tdata_i[2:0] > OP_DEL) begin
            res_d.status = ST_BADOP; state_d = S_OUT;
          end else state_d = S_MOD;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          addr_d = AW'(32'(rem) * WAYS); state_d = S_RD;
          way_d = '0; mfound_d = 1'b0; efound_d = 1'b0;
        end
      end
      S_RD: state_d = S_CMP;
      S_CMP: begin
        if (!mfound_d && e_match) begin
          mfound_d = 1'b1; mway_d = way_q[WW-1:0];
          mblk_d = rdata_q[BLOCK_BITS-1:0];
        end
        if (!efound_q && e_empty) begin
          efound_d = 1'b1; eway_d = way_q[WW-1:0];
        end
        if (way_q == (WW+1)'(WAYS - 1)) state_d = S_WB;
        else begin
          way_d = way_q + 1'b1; addr_d = addr_q + 1'b1; state_d = S_RD;
        end
      end
      S_WB: begin
        state_d = S_OUT;
        res_d.hit = mfound_q;
        res_d.entry_index = mfound_q ? 12'(idx) : 12'd0;
        unique case (op_q)
          OP_GET: begin
            if (mfound_q) res_d.found_block = 32'(mblk_q);
            else res_d.status = ST_MISSING;
          end
          OP_PUT: begin
            if (!nz) res_d.status = ST_WFAIL;
            else if (!mfound_q && !efound_q) res_d.status = ST_FULL;
            else begin
              res_d.entry_index = 12'(idx);
              if (!ok) res_d.status = ST_WFAIL;
              else begin
                we = 1'b1; wdata = {tag_q, nb_q};
                res_d.freed_block = 32'(oblk); res_d.freed_valid = oblk != '0;
              end
            end
          end
          OP_UPD, OP_DEL: begin
            if (mfound_q) begin
              we = 1'b1;
              res_d.freed_block = 32'(oblk); res_d.freed_valid = oblk != '0;
              if (op_q == OP_UPD && ok) wdata = {tag_q, nb_q};
              else if (op_q == OP_UPD) res_d.status = ST_WFAIL;
            end
          end
          default: res_d.status = ST_BADOP;
        endcase
      end
      S_OUT: if (m_axis_tready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR; clr_q <= '0; bc_q <= 9'd256;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) clr_q <= clr_q + 1'b1;
      if (cfg_we_i) bc_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && s_axis_tvalid_i) begin
      op_q <= s_axis_tdata_i[2:0];
      tag_q <= s_axis_tdata_i[162:35];
      nb_q <= s_axis_tdata_i[163 +: BLOCK_BITS]; okin_q <= s_axis_tdata_i[195];
    end
    if (state_q == S_MOD && mod_done) base_q <= addr_d;
    addr_q <= addr_d; way_q <= way_d;
    mfound_q <= mfound_d; mway_q <= mway_d; efound_q <= efound_d; eway_q <= eway_d;
    mblk_q <= mblk_d; res_q <= res_d;
  end

  assign s_axis_tready_o = state_q == S_IDLE;
  assign m_axis_tvalid_o = state_q == S_OUT;
  assign m_axis_tdata_o = {7'd0, res_q.freed_valid, res_q.freed_block,
    res_q.found_block, res_q.entry_index, res_q.hit, res_q.status};

  `BHKV_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, m_axis_tvalid_o, !s_axis_tready_o)
  `BHKV_ASSERT_NXT(a_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i,
    m_axis_tvalid_o && $stable(m_axis_tdata_o))
  `BHKV_ASSERT_IMP(a_freed, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tdata_o[80],
    m_axis_tdata_o[79:48] != 32'd0)
endmodule
`default_nettype wire
